// ===== rtl/mpeg_audio_header_sync_decode_macros.svh =====
// Assertion macros shared by the MPEG audio header sync decoder.
// No dependencies; included by the top level.
`ifndef MPEG_AUDIO_HEADER_SYNC_DECODE_MACROS_SVH
`define MPEG_AUDIO_HEADER_SYNC_DECODE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAHSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mahsd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAHSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mahsd assertion failed");

`endif

// ===== rtl/mahsd_pkg.sv =====
// Types, header codes and lookup tables of the MPEG audio header sync decoder.
// No dependencies; used by every module of the block.
package mahsd_pkg;

    localparam logic [1:0] VER_MPEG25 = 2'd0;
    localparam logic [1:0] VER_RSVD   = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] VER_MPEG1  = 2'd3;

    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_3    = 2'd1;
    localparam logic [1:0] LAYER_2    = 2'd2;
    localparam logic [1:0] LAYER_1    = 2'd3;

    localparam logic [3:0] BRI_BAD    = 4'd15;
    localparam logic [1:0] SRI_RSVD   = 2'd3;

    // Width of the frame-size dividend (largest is 144 * 384000) and division steps.
    localparam int NUM_W     = 26;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [10:0] SPF_L1  = 11'd384;
    localparam logic [10:0] SPF_L2  = 11'd1152;
    localparam logic [10:0] SPF_L3H = 11'd576;

    localparam logic [15:0] SR_44K = 16'd44100;
    localparam logic [15:0] SR_48K = 16'd48000;
    localparam logic [15:0] SR_32K = 16'd32000;

    // Frame-size constant already multiplied by 1000 (bitrate is kept in kbit/s).
    localparam logic [17:0] FC_L1   = 18'd12000;
    localparam logic [17:0] FC_HALF = 18'd72000;
    localparam logic [17:0] FC_FULL = 18'd144000;

    localparam logic [9:0] KBPS_SCALE = 10'd1000;

    localparam logic [8:0] RATE_V1 [0:2][0:14] = '{
        '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
          9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
        '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
          9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320}
    };

    localparam logic [8:0] RATE_V2 [0:1][0:14] = '{
        '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
          9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
        '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
          9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [15:0] skipped_bytes;
        logic [1:0]  version_code;
        logic [1:0]  layer_code;
        logic [10:0] samples_per_frame;
        logic [15:0] sample_rate_hz;
        logic [18:0] bitrate_bps;
        logic        padded;
        logic [11:0] frame_bytes;
        logic        bad_frame;
    } t_out_item;

    // One found header waiting for the decoder.
    typedef struct packed {
        logic [15:0] skip;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  bri;
        logic [1:0]  sri;
        logic        pad;
    } t_hdr_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_DIV,
        DEC_HOLD
    } t_dec_state;

    function automatic logic [8:0] bitrate_kbps(logic [1:0] ver, logic [1:0] lay,
                                                logic [3:0] bri);
        logic [8:0] k;
        logic [1:0] row;
        k   = '0;
        row = 2'(LAYER_1 - lay);
        if (bri != BRI_BAD && lay != LAYER_RSVD) begin
            if (ver == VER_MPEG1) begin
                k = RATE_V1[row][bri];
            end else if (lay == LAYER_1) begin
                k = RATE_V2[0][bri];
            end else begin
                k = RATE_V2[1][bri];
            end
        end
        return k;
    endfunction

    function automatic logic [15:0] sample_rate(logic [1:0] ver, logic [1:0] sri);
        logic [15:0] base;
        case (sri)
            2'd0:    base = SR_44K;
            2'd1:    base = SR_48K;
            2'd2:    base = SR_32K;
            default: base = '0;
        endcase
        case (ver)
            VER_MPEG2:  base = base >> 1;
            VER_MPEG25: base = base >> 2;
            default:    base = base;
        endcase
        return base;
    endfunction

    function automatic logic [10:0] samples_per_frame(logic [1:0] ver, logic [1:0] lay);
        logic [10:0] s;
        case (lay)
            LAYER_1: s = SPF_L1;
            LAYER_2: s = SPF_L2;
            LAYER_3: s = (ver == VER_MPEG1) ? SPF_L2 : SPF_L3H;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [17:0] frame_const(logic [1:0] ver, logic [1:0] lay);
        logic [17:0] c;
        if (lay == LAYER_1) begin
            c = FC_L1;
        end else if (lay == LAYER_3 && (ver == VER_MPEG2 || ver == VER_MPEG25)) begin
            c = FC_HALF;
        end else begin
            c = FC_FULL;
        end
        return c;
    endfunction

endpackage

// ===== rtl/mahsd_sync.sv =====
// Front end: byte window, frame-sync search and skip counting.
// Depends on mahsd_pkg; feeds found headers into mahsd_fifo.
module mahsd_sync (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  mahsd_pkg::t_in_item   i_in,
    input  mahsd_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_fifo_push,
    output mahsd_pkg::t_hdr_entry o_entry
);

    logic [31:0] r_window, n_window;
    logic [2:0]  r_held, n_held;
    logic [15:0] r_skip, n_skip;

    logic        accept;
    logic [31:0] base_window, win;
    logic [2:0]  base_held, held;
    logic [15:0] base_skip;
    logic        match;

    assign o_full = i_fifo_stat.full;
    assign accept = i_push && !i_fifo_stat.full;

    always_comb begin
        base_window = i_in.restart ? '0 : r_window;
        base_held   = i_in.restart ? '0 : r_held;
        base_skip   = i_in.restart ? '0 : r_skip;
        win         = {base_window[23:0], i_in.data_byte};
        held        = (base_held < 3'd4) ? 3'(base_held + 3'd1) : 3'd4;
        match       = (held == 3'd4) && (win[31:21] == '1);

        n_window = r_window;
        n_held   = r_held;
        n_skip   = r_skip;
        if (accept) begin
            if (match) begin
                n_window = '0;
                n_held   = '0;
                n_skip   = '0;
            end else begin
                n_window = win;
                n_held   = held;
                n_skip   = base_skip;
                if (held == 3'd4 && base_skip != '1) begin
                    n_skip = 16'(base_skip + 16'd1);
                end
            end
        end
    end

    assign o_fifo_push = accept && match;
    assign o_entry     = '{skip: base_skip, ver: win[20:19], lay: win[18:17],
                           bri: win[15:12], sri: win[11:10], pad: win[9]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_held   <= '0;
            r_skip   <= '0;
        end else begin
            r_window <= n_window;
            r_held   <= n_held;
            r_skip   <= n_skip;
        end
    end

endmodule

// ===== rtl/mahsd_fifo.sv =====
// Short header queue between the sync front end and the decoder.
// Depends on mahsd_pkg for the entry and status types.
module mahsd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mahsd_pkg::t_hdr_entry i_entry,
    input  logic                  i_pop,
    output mahsd_pkg::t_hdr_entry o_head,
    output mahsd_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    mahsd_pkg::t_hdr_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : PTR_W'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : PTR_W'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CNT_W'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== rtl/mahsd_decode.sv =====
// Back end: table lookups, serial frame-size division and the result register.
// Depends on mahsd_pkg; takes headers from mahsd_fifo.
module mahsd_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mahsd_pkg::t_hdr_entry i_head,
    input  mahsd_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_fifo_pop,
    output logic                  o_busy,
    input  logic                  pop,
    output logic                  empty,
    output mahsd_pkg::t_out_item  o_out
);

    localparam int NW = mahsd_pkg::NUM_W;
    localparam int SW = mahsd_pkg::STEP_W;

    mahsd_pkg::t_dec_state r_state, n_state;

    logic [SW-1:0] r_step;
    logic [NW-1:0] r_quo;
    logic [15:0]   r_rem;
    logic [15:0]   r_sr;
    logic [8:0]    r_kbps;
    logic [10:0]   r_spf;
    logic [15:0]   r_skip;
    logic [1:0]    r_ver, r_lay;
    logic          r_pad, r_bad;
    logic          r_out_valid;
    mahsd_pkg::t_out_item r_out;

    logic          load_in, load_out, last_step;
    logic [8:0]    head_kbps;
    logic [26:0]   head_num;
    logic [16:0]   rem_sh;
    logic          ge;
    logic          zero_fb;
    logic [11:0]   fb_sum;
    logic [11:0]   fb;
    logic [18:0]   br_bps;

    assign last_step = (r_step == SW'(mahsd_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            mahsd_pkg::DEC_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    n_state = mahsd_pkg::DEC_DIV;
                end
            end
            mahsd_pkg::DEC_DIV: begin
                if (last_step) begin
                    n_state = mahsd_pkg::DEC_HOLD;
                end
            end
            mahsd_pkg::DEC_HOLD: begin
                if (!r_out_valid || pop) begin
                    n_state = mahsd_pkg::DEC_IDLE;
                end
            end
            default: n_state = mahsd_pkg::DEC_IDLE;
        endcase
    end

    always_comb begin
        load_in  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            mahsd_pkg::DEC_IDLE: load_in  = !i_fifo_stat.empty;
            mahsd_pkg::DEC_HOLD: load_out = !r_out_valid || pop;
            default: begin
                load_in  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign o_fifo_pop = load_in;
    assign o_busy     = (r_state != mahsd_pkg::DEC_IDLE);

    // Dividend is the frame constant times the bitrate in kbit/s.
    assign head_kbps = mahsd_pkg::bitrate_kbps(i_head.ver, i_head.lay, i_head.bri);
    assign head_num  = mahsd_pkg::frame_const(i_head.ver, i_head.lay) * head_kbps;

    // One restoring division step per cycle.
    assign rem_sh = {1'b0, r_rem} << 1 | 17'(r_quo[NW-1]);
    assign ge     = (rem_sh >= {1'b0, r_sr});

    assign zero_fb = r_bad || (r_kbps == '0) || (r_sr == '0);
    assign fb_sum  = 12'(r_quo[11:0] + 12'(r_pad));
    assign fb      = zero_fb ? '0 :
                     (r_lay == mahsd_pkg::LAYER_1) ? {fb_sum[9:0], 2'b00} : fb_sum;
    assign br_bps  = 19'(r_kbps * mahsd_pkg::KBPS_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mahsd_pkg::DEC_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_in) begin
                r_step <= '0;
            end else if (r_state == mahsd_pkg::DEC_DIV) begin
                r_step <= SW'(r_step + 1'b1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_quo  <= head_num[NW-1:0];
            r_rem  <= '0;
            r_sr   <= mahsd_pkg::sample_rate(i_head.ver, i_head.sri);
            r_kbps <= head_kbps;
            r_spf  <= mahsd_pkg::samples_per_frame(i_head.ver, i_head.lay);
            r_skip <= i_head.skip;
            r_ver  <= i_head.ver;
            r_lay  <= i_head.lay;
            r_pad  <= i_head.pad;
            r_bad  <= (i_head.bri == mahsd_pkg::BRI_BAD) ||
                      (i_head.lay == mahsd_pkg::LAYER_RSVD);
        end else if (r_state == mahsd_pkg::DEC_DIV) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? 16'(rem_sh - {1'b0, r_sr}) : rem_sh[15:0];
        end
        if (load_out) begin
            r_out <= '{skipped_bytes: r_skip, version_code: r_ver, layer_code: r_lay,
                       samples_per_frame: r_spf, sample_rate_hz: r_sr,
                       bitrate_bps: br_bps, padded: r_pad, frame_bytes: fb,
                       bad_frame: r_bad};
        end
    end

    assign empty = !r_out_valid;
    assign o_out = r_out;

endmodule

// ===== rtl/mpeg_audio_header_sync_decode.sv =====
// Top level of the MPEG audio frame header finder and decoder.
// Depends on mahsd_pkg, mahsd_sync, mahsd_fifo, mahsd_decode and the macro header.
`include "mpeg_audio_header_sync_decode_macros.svh"

// Stream bytes enter through a queue-like port and are taken one per clock as
// long as full is low. The front end shifts each byte into a 32-bit window
// (newest byte lowest) and, once four bytes are held and the eleven sync bits
// are all ones, hands the header fields and the count of bytes slid past to a
// queue of QUEUE_DEPTH entries; the window and skip count then clear. A byte
// with restart set clears the window and the skip count before it is taken.
// The decoder takes one header at a time: table lookups and the dividend
// multiply as the header is loaded, a one-bit-per-cycle restoring divider for
// the frame size, and a step into the result register. Since headers lie at
// least four bytes apart, bytes flow at one per clock unless headers arrive
// faster than the decoder finishes them for longer than the queue absorbs;
// full then rises until the decoder frees an entry. A result waits on o_out
// while empty is low and leaves on pop; the decoder can finish the next
// header meanwhile.
module mpeg_audio_header_sync_decode #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  mahsd_pkg::t_in_item  i_in,
    output logic                 empty,
    input  logic                 pop,
    output mahsd_pkg::t_out_item o_out
);

    mahsd_pkg::t_fifo_stat fifo_stat;
    mahsd_pkg::t_hdr_entry sync_entry;
    mahsd_pkg::t_hdr_entry fifo_head;
    logic                  fifo_push;
    logic                  fifo_pop;
    logic                  dec_busy;

    mahsd_sync u_sync (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .i_fifo_stat (fifo_stat),
        .o_fifo_push (fifo_push),
        .o_entry     (sync_entry)
    );

    mahsd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_entry (sync_entry),
        .i_pop   (fifo_pop),
        .o_head  (fifo_head),
        .o_stat  (fifo_stat)
    );

    mahsd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (fifo_head),
        .i_fifo_stat (fifo_stat),
        .o_fifo_pop  (fifo_pop),
        .o_busy      (dec_busy),
        .pop         (pop),
        .empty       (empty),
        .o_out       (o_out)
    );

    // A header is never pushed into a full queue.
    `MAHSD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, fifo_push, !fifo_stat.full)

    // The decoder takes a new header only when it has finished the last one.
    `MAHSD_ASSERT_NOW(a_pop_when_idle, i_clk, i_rst_n, fifo_pop, !dec_busy && !fifo_stat.empty)

    // A bad frame carries no bitrate and no frame size.
    `MAHSD_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, !empty && o_out.bad_frame, o_out.bitrate_bps == '0 && o_out.frame_bytes == '0)

    // Taking a header always moves the decoder out of idle.
    `MAHSD_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, fifo_pop, dec_busy)

endmodule
